// File: sv/lnes_pkg.sv
// Shared types, constants and a helper function for the looping note sequencer.
package lnes_pkg;

   localparam int NOTE_DEPTH  = 4096;
   localparam int NOTE_AW     = $clog2(NOTE_DEPTH);
   localparam int TRACK_SLOTS = 3;
   localparam int MAX_BURST   = 64;
   localparam int BURST_W     = $clog2(MAX_BURST + 1);
   localparam int CLK_W       = 34;

   localparam logic [1:0]  SILENT_TRACK  = 2'd3;
   localparam logic [19:0] STEP_LIMIT_US = 20'd250000;

   typedef enum logic [1:0] {
      ACT_LOAD_NOTE  = 2'd0,
      ACT_LOAD_SLICE = 2'd1,
      ACT_PLAY       = 2'd2,
      ACT_TICK       = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_CMP,
      ST_DIV,
      ST_WALK,
      ST_READ,
      ST_CHK,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [23:0] time_ms;
      logic [14:0] dur_ms;
      logic [6:0]  pitch;
      logic [6:0]  vel;
      logic [1:0]  wave;
   } note_type;

   localparam int NOTE_W = $bits(note_type);

   typedef struct packed {
      logic [1:0]  wave;
      logic [13:0] freq;
      logic [14:0] dur;
      logic [5:0]  gain;
   } event_type;

   localparam logic [13:0] PITCH_HZ [128] = '{
      14'd8, 14'd8, 14'd9, 14'd9, 14'd10, 14'd10, 14'd11, 14'd12, 14'd12, 14'd13,
      14'd14, 14'd15, 14'd16, 14'd17, 14'd18, 14'd19, 14'd20, 14'd21, 14'd23, 14'd24,
      14'd25, 14'd27, 14'd29, 14'd30, 14'd32, 14'd34, 14'd36, 14'd38, 14'd41, 14'd43,
      14'd46, 14'd48, 14'd51, 14'd55, 14'd58, 14'd61, 14'd65, 14'd69, 14'd73, 14'd77,
      14'd82, 14'd87, 14'd92, 14'd97, 14'd103, 14'd110, 14'd116, 14'd123, 14'd130,
      14'd138, 14'd146, 14'd155, 14'd164, 14'd174, 14'd184, 14'd195, 14'd207, 14'd220,
      14'd233, 14'd246, 14'd261, 14'd277, 14'd293, 14'd311, 14'd329, 14'd349, 14'd369,
      14'd391, 14'd415, 14'd440, 14'd466, 14'd493, 14'd523, 14'd554, 14'd587, 14'd622,
      14'd659, 14'd698, 14'd739, 14'd783, 14'd830, 14'd880, 14'd932, 14'd987,
      14'd1046, 14'd1108, 14'd1174, 14'd1244, 14'd1318, 14'd1396, 14'd1479, 14'd1567,
      14'd1661, 14'd1760, 14'd1864, 14'd1975, 14'd2093, 14'd2217, 14'd2349, 14'd2489,
      14'd2637, 14'd2793, 14'd2959, 14'd3135, 14'd3322, 14'd3520, 14'd3729, 14'd3951,
      14'd4186, 14'd4434, 14'd4698, 14'd4978, 14'd5274, 14'd5587, 14'd5919, 14'd6271,
      14'd6644, 14'd7040, 14'd7458, 14'd7902, 14'd8372, 14'd8869, 14'd9397, 14'd9956,
      14'd10548, 14'd11175, 14'd11839, 14'd12543
   };

   // 34*v/127 via reciprocal estimate (never low by more than one) and one fixup
   function automatic logic [5:0] gain_of(input logic [6:0] v);
      logic [12:0] x;
      logic [22:0] p;
      logic [5:0]  q;
      logic [12:0] r;
      x = {1'b0, v, 5'b0} + {5'b0, v, 1'b0};
      p = 23'(x) * 23'd516;
      q = p[21:16];
      r = x - 13'(q * 13'd127);
      if (r >= 13'd127) begin
         q = q + 6'd1;
      end
      return q;
   endfunction

endpackage

// File: sv/lnes_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lnes_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// File: sv/lnes_rem.sv
// Bit-serial restoring remainder unit for wrapping the microsecond clock.
module lnes_rem import lnes_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CLK_W-1:0] dividend,
   input  logic [CLK_W-1:0] divisor,
   output logic             done_ff,
   output logic [CLK_W-1:0] rem_ff
);

   localparam int CNT_W = $clog2(CLK_W + 1);

   logic [CLK_W-1:0] num_ff, num_in;
   logic [CLK_W-1:0] rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_in;
   logic [CLK_W:0]   trial;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[CLK_W-1]};
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(CLK_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = CLK_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[CLK_W-1:0];
         end
         num_in = {num_ff[CLK_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

endmodule

// File: sv/looping_note_event_sequencer.sv
// Top level of the looping note-event sequencer: control, slice table and note memory.
//
// Input channel (req_*): one item per accepted valid/stall handshake. Load-note,
// load-slice and play items finish in the cycle they are accepted; req_stall is
// low again on the next cycle. A tick item holds req_stall high while it runs.
// Result channel (rsp_*): one item per emitted note, rsp_last marks the final
// note of a tick. A tick walks the slice's due notes one at a time: each is
// read from the note memory and then compared; when the clock wraps, the
// bit-serial remainder unit runs before the walk. A tick on silence or an
// empty slice returns to idle without walking any notes.
// Results wait in an output register; when the receiver holds rsp_stall the
// walker pauses with one further note held back, and resumes when the register
// frees up. The last note of a tick is released only once the walk ends: the next
// note is not due, the slice end is reached or the MAX_BURST limit is hit.
// Reset (synchronous, active high) clears the slice table, the clock and the
// cursor, selects silence and empties the output; the note memory is not
// cleared and must be loaded before it is played.
module looping_note_event_sequencer import lnes_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [11:0] req_note_index,
   input  logic [1:0]  req_track_id,
   input  logic [23:0] req_note_time_ms,
   input  logic [14:0] req_note_duration_ms,
   input  logic [6:0]  req_pitch,
   input  logic [6:0]  req_velocity,
   input  logic [1:0]  req_waveform,
   input  logic [11:0] req_slice_first,
   input  logic [12:0] req_slice_count,
   input  logic [23:0] req_loop_length_ms,
   input  logic [19:0] req_step_us,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_wave_out,
   output logic [13:0] rsp_frequency_hz,
   output logic [14:0] rsp_duration_out_ms,
   output logic [5:0]  rsp_gain,
   output logic        rsp_last
);

   localparam int IDX_W = NOTE_AW + 1;

   state_type state_ff, state_in;

   logic [11:0] sl_first_ff [TRACK_SLOTS];
   logic [12:0] sl_count_ff [TRACK_SLOTS];
   logic [23:0] sl_len_ff   [TRACK_SLOTS];

   logic [1:0]       track_ff, track_in;
   logic [CLK_W-1:0] clock_us_ff, clock_us_in;
   logic [IDX_W-1:0] next_ff, next_in;
   logic [CLK_W-1:0] loop_ff, loop_in;
   logic [IDX_W-1:0] end_ff, end_in;
   logic [11:0]      first_ff, first_in;
   logic [19:0]      step_ff, step_in;
   logic [BURST_W-1:0] burst_ff, burst_in;
   logic [CLK_W-1:0] prod_ff, prod_in;
   note_type         cand_ff, cand_in;
   event_type        hold_ff, hold_in, out_ff, out_in;
   logic             hold_v_ff, hold_v_in;
   logic             out_v_ff, out_v_in;
   logic             out_last_ff, out_last_in;

   logic        accept;
   action_type  act;
   logic [1:0]  slot_sel;
   logic        slot_ok;
   logic [11:0] sel_first;
   logic [12:0] sel_count;
   logic [23:0] sel_len;
   logic        out_free;
   logic        rem_start, rem_done;
   logic [CLK_W-1:0] rem_val;
   logic        rd_en;
   note_type    rd_note;
   logic [NOTE_W-1:0] rd_word;
   logic        mem_we;
   logic [13:0] end_raw;
   logic [23:0] len_eff;

   assign accept    = req_valid && !req_stall;
   assign act       = action_type'(req_action);
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !out_v_ff || !rsp_stall;
   assign rd_note   = note_type'(rd_word);
   assign mem_we    = accept && (act == ACT_LOAD_NOTE) &&
                      ({1'b0, req_note_index} < 13'(NOTE_DEPTH));

   // one read port on the slice table: the request's slot when idle, else the playing one
   assign slot_sel  = (state_ff == ST_IDLE) ? req_track_id : track_ff;
   assign slot_ok   = (32'(slot_sel) < TRACK_SLOTS);
   assign sel_first = slot_ok ? sl_first_ff[slot_sel] : '0;
   assign sel_count = slot_ok ? sl_count_ff[slot_sel] : '0;
   assign sel_len   = slot_ok ? sl_len_ff[slot_sel] : '0;
   assign len_eff   = (sel_len == '0) ? 24'd1 : sel_len;
   assign end_raw   = 14'(sel_first) + 14'(sel_count);

   lnes_ram #(.WIDTH(NOTE_W), .DEPTH(NOTE_DEPTH)) u_note_ram (
      .clock      (clock),
      .wr_en      (mem_we),
      .wr_addr    (req_note_index[NOTE_AW-1:0]),
      .wr_data    ({req_note_time_ms, req_note_duration_ms, req_pitch,
                    req_velocity, req_waveform}),
      .rd_en      (rd_en),
      .rd_addr    (next_ff[NOTE_AW-1:0]),
      .rd_data_ff (rd_word)
   );

   lnes_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (clock_us_ff),
      .divisor  (loop_ff),
      .done_ff  (rem_done),
      .rem_ff   (rem_val)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TRACK_SLOTS; i++) begin
            sl_first_ff[i] <= '0;
            sl_count_ff[i] <= '0;
            sl_len_ff[i]   <= '0;
         end
      end else if (accept && (act == ACT_LOAD_SLICE) && slot_ok) begin
         sl_first_ff[slot_sel] <= req_slice_first;
         sl_count_ff[slot_sel] <= req_slice_count;
         sl_len_ff[slot_sel]   <= (req_loop_length_ms == '0) ? 24'd1 : req_loop_length_ms;
      end
   end

   always_comb begin
      state_in    = state_ff;
      track_in    = track_ff;
      clock_us_in = clock_us_ff;
      next_in     = next_ff;
      loop_in     = loop_ff;
      end_in      = end_ff;
      first_in    = first_ff;
      step_in     = step_ff;
      burst_in    = burst_ff;
      prod_in     = prod_ff;
      cand_in     = cand_ff;
      hold_in     = hold_ff;
      hold_v_in   = hold_v_ff;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      out_v_in    = out_v_ff && rsp_stall;
      rem_start   = 1'b0;
      rd_en       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (act)
                  ACT_PLAY: begin
                     if (!slot_ok) begin
                        if (track_ff != SILENT_TRACK) begin
                           track_in    = SILENT_TRACK;
                           clock_us_in = '0;
                           next_in     = '0;
                        end
                     end else if (req_track_id != track_ff) begin
                        track_in    = req_track_id;
                        clock_us_in = '0;
                        next_in     = IDX_W'(sel_first);
                     end
                  end
                  ACT_TICK: begin
                     step_in  = (req_step_us > STEP_LIMIT_US) ? STEP_LIMIT_US : req_step_us;
                     state_in = ST_TICK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TICK: begin
            if (!slot_ok || sel_count == '0) begin
               state_in = ST_IDLE;
            end else begin
               clock_us_in = clock_us_ff + CLK_W'(step_ff);
               loop_in     = CLK_W'(len_eff) * CLK_W'(1000);
               end_in      = (end_raw > 14'(NOTE_DEPTH)) ? IDX_W'(NOTE_DEPTH)
                                                        : IDX_W'(end_raw);
               first_in    = sel_first;
               burst_in    = '0;
               state_in    = ST_CMP;
            end
         end
         ST_CMP: begin
            if (clock_us_ff >= loop_ff) begin
               rem_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_DIV: begin
            if (rem_done) begin
               clock_us_in = rem_val;
               next_in     = IDX_W'(first_ff);
               state_in    = ST_WALK;
            end
         end
         ST_WALK: begin
            if (burst_ff < BURST_W'(MAX_BURST) && next_ff < end_ff) begin
               rd_en    = 1'b1;
               state_in = ST_READ;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_READ: begin
            cand_in  = rd_note;
            prod_in  = CLK_W'(rd_note.time_ms) * CLK_W'(1000);
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (prod_ff <= clock_us_ff) begin
               if (!hold_v_ff || out_free) begin
                  if (hold_v_ff) begin
                     out_in      = hold_ff;
                     out_last_in = 1'b0;
                     out_v_in    = 1'b1;
                  end
                  hold_in.wave = cand_ff.wave;
                  hold_in.freq = PITCH_HZ[cand_ff.pitch];
                  hold_in.dur  = cand_ff.dur_ms;
                  hold_in.gain = gain_of(cand_ff.vel);
                  hold_v_in    = 1'b1;
                  next_in      = next_ff + IDX_W'(1);
                  burst_in     = burst_ff + BURST_W'(1);
                  state_in     = ST_WALK;
               end
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!hold_v_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_in      = hold_ff;
               out_last_in = 1'b1;
               out_v_in    = 1'b1;
               hold_v_in   = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         track_ff    <= SILENT_TRACK;
         clock_us_ff <= '0;
         next_ff     <= '0;
         hold_v_ff   <= 1'b0;
         out_v_ff    <= 1'b0;
         burst_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         track_ff    <= track_in;
         clock_us_ff <= clock_us_in;
         next_ff     <= next_in;
         hold_v_ff   <= hold_v_in;
         out_v_ff    <= out_v_in;
         burst_ff    <= burst_in;
      end
      loop_ff     <= loop_in;
      end_ff      <= end_in;
      first_ff    <= first_in;
      step_ff     <= step_in;
      prod_ff     <= prod_in;
      cand_ff     <= cand_in;
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid           = out_v_ff;
   assign rsp_wave_out        = out_ff.wave;
   assign rsp_frequency_hz    = out_ff.freq;
   assign rsp_duration_out_ms = out_ff.dur;
   assign rsp_gain            = out_ff.gain;
   assign rsp_last            = out_last_ff;

endmodule

// File: sv/lnes_checker.sv
// Port-level checks for the looping note sequencer, bound to the top level.
module lnes_checker import lnes_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_action,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [13:0] rsp_frequency_hz,
   input logic [5:0]  rsp_gain,
   input logic        rsp_last
);

   // loads and plays complete in the accept cycle
   a_short_items: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action != ACT_TICK |=> !req_stall)
      else $error("block busy after a load or play item");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frequency_hz) &&
      $stable(rsp_gain) && $stable(rsp_last))
      else $error("stalled result changed");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_gain <= 6'd34)
      else $error("gain out of range");

endmodule

bind looping_note_event_sequencer lnes_checker u_lnes_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_action       (req_action),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_frequency_hz (rsp_frequency_hz),
   .rsp_gain         (rsp_gain),
   .rsp_last         (rsp_last)
);

// File: verif/looping_note_event_sequencer_test.sv
// Self-checking testbench for the looping note-event sequencer.
module looping_note_event_sequencer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lnes_pkg::*;

   localparam int LO_END   = 80;     // notes 0..79 are loaded
   localparam int HI_START = 4016;   // notes 4016..4095 are loaded
   localparam int QUIET_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = '0;
   logic [11:0] req_note_index = '0;
   logic [1:0]  req_track_id = '0;
   logic [23:0] req_note_time_ms = '0;
   logic [14:0] req_note_duration_ms = '0;
   logic [6:0]  req_pitch = '0;
   logic [6:0]  req_velocity = '0;
   logic [1:0]  req_waveform = '0;
   logic [11:0] req_slice_first = '0;
   logic [12:0] req_slice_count = '0;
   logic [23:0] req_loop_length_ms = '0;
   logic [19:0] req_step_us = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_wave_out;
   logic [13:0] rsp_frequency_hz;
   logic [14:0] rsp_duration_out_ms;
   logic [5:0]  rsp_gain;
   logic        rsp_last;

   looping_note_event_sequencer dut (.*);

   always #1 clock = ~clock;

   typedef struct {
      action_type  act;
      logic [11:0] idx;
      logic [1:0]  tid;
      logic [23:0] t_ms;
      logic [14:0] dur;
      logic [6:0]  pitch;
      logic [6:0]  vel;
      logic [1:0]  wave;
      logic [11:0] first;
      logic [12:0] count;
      logic [23:0] len;
      logic [19:0] step;
   } seq_cmd;

   typedef struct {
      logic [1:0]  wave;
      logic [13:0] freq;
      logic [14:0] dur;
      logic [5:0]  gain;
      logic        last;
   } note_event;

   note_event due_events[$];

   // shadow of the sequencer
   logic [23:0] mem_time [NOTE_DEPTH];
   logic [14:0] mem_dur [NOTE_DEPTH];
   logic [6:0]  mem_pitch [NOTE_DEPTH];
   logic [6:0]  mem_vel [NOTE_DEPTH];
   logic [1:0]  mem_wave [NOTE_DEPTH];
   logic [11:0] trk_first [TRACK_SLOTS];
   logic [12:0] trk_count [TRACK_SLOTS];
   logic [23:0] trk_len [TRACK_SLOTS];
   bit          trk_hi [TRACK_SLOTS];   // which loaded region the slice lives in
   logic [1:0]  playing = SILENT_TRACK;
   longint unsigned pos_us = 0;
   int          cursor = 0;

   int errors = 0;
   int quiet = 0;
   bit idle_en = 1'b1;
   int rx_wait = 0;
   int rx_hold = 0;

   initial begin
      for (int i = 0; i < TRACK_SLOTS; i++) begin
         trk_first[i] = '0;
         trk_count[i] = '0;
         trk_len[i] = '0;
         trk_hi[i] = 1'b0;
      end
   end

   task automatic play_cmd(input seq_cmd c);
      int n;
      int stop;
      longint unsigned loop_us;
      logic [19:0] st;
      logic [1:0] tid;
      note_event e;
      case (c.act)
         ACT_LOAD_NOTE: begin
            mem_time[c.idx] = c.t_ms;
            mem_dur[c.idx] = c.dur;
            mem_pitch[c.idx] = c.pitch;
            mem_vel[c.idx] = c.vel;
            mem_wave[c.idx] = c.wave;
         end
         ACT_LOAD_SLICE: begin
            if (c.tid < TRACK_SLOTS) begin
               trk_first[c.tid] = c.first;
               trk_count[c.tid] = c.count;
               trk_len[c.tid] = (c.len == 0) ? 24'd1 : c.len;
            end
         end
         ACT_PLAY: begin
            tid = (c.tid >= TRACK_SLOTS) ? SILENT_TRACK : c.tid;
            if (tid != playing) begin
               playing = tid;
               pos_us = 0;
               cursor = (tid < TRACK_SLOTS) ? int'(trk_first[tid]) : 0;
            end
         end
         ACT_TICK: begin
            if (playing < TRACK_SLOTS && trk_count[playing] != 0) begin
               st = (c.step > STEP_LIMIT_US) ? STEP_LIMIT_US : c.step;
               pos_us += st;
               loop_us = longint'(trk_len[playing]) * 64'd1000;
               if (pos_us >= loop_us) begin
                  pos_us = pos_us % loop_us;
                  cursor = int'(trk_first[playing]);
               end
               stop = int'(trk_first[playing]) + int'(trk_count[playing]);
               if (stop > NOTE_DEPTH) stop = NOTE_DEPTH;
               n = 0;
               while (n < MAX_BURST && cursor < stop &&
                      longint'(mem_time[cursor]) * 64'd1000 <= pos_us) begin
                  e.wave = mem_wave[cursor];
                  e.freq = PITCH_HZ[mem_pitch[cursor]];
                  e.dur  = mem_dur[cursor];
                  e.gain = 6'((34 * int'(mem_vel[cursor])) / 127);
                  e.last = 1'b0;
                  due_events.push_back(e);
                  cursor++;
                  n++;
               end
               if (n > 0) due_events[due_events.size() - 1].last = 1'b1;
            end
         end
      endcase
   endtask

   function automatic seq_cmd rand_cmd(input action_type act);
      seq_cmd c;
      c.act   = act;
      c.idx   = 12'($urandom);
      c.tid   = 2'($urandom);
      c.t_ms  = 24'($urandom);
      c.dur   = 15'($urandom);
      c.pitch = 7'($urandom);
      c.vel   = 7'($urandom);
      c.wave  = 2'($urandom);
      c.first = 12'($urandom);
      c.count = 13'($urandom_range(0, 4096));
      c.len   = 24'($urandom);
      c.step  = 20'($urandom_range(0, 1000000));
      return c;
   endfunction

   // entered and left at a falling edge
   task automatic send_item(input seq_cmd c);
      int gap;
      gap = idle_en ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_action = c.act;
      req_note_index = c.idx;
      req_track_id = c.tid;
      req_note_time_ms = c.t_ms;
      req_note_duration_ms = c.dur;
      req_pitch = c.pitch;
      req_velocity = c.vel;
      req_waveform = c.wave;
      req_slice_first = c.first;
      req_slice_count = c.count;
      req_loop_length_ms = c.len;
      req_step_us = c.step;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      play_cmd(c);
      @(negedge clock);
   endtask

   task automatic send_slice(input logic [1:0] tid, input int first, input int count,
                             input logic [23:0] len, input bit hi);
      seq_cmd c;
      c = rand_cmd(ACT_LOAD_SLICE);
      c.tid = tid;
      c.first = 12'(first);
      c.count = 13'(count);
      c.len = len;
      if (tid < TRACK_SLOTS) trk_hi[tid] = hi;
      send_item(c);
   endtask

   task automatic send_play(input logic [1:0] tid);
      seq_cmd c;
      c = rand_cmd(ACT_PLAY);
      c.tid = tid;
      send_item(c);
   endtask

   task automatic send_tick(input logic [19:0] step);
      seq_cmd c;
      c = rand_cmd(ACT_TICK);
      c.step = step;
      send_item(c);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (due_events.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   // result side: stall draw, long hold, and the check
   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rsp_stall <= 1'b1;
         rx_hold--;
      end else if (rx_wait > 0) begin
         rsp_stall <= 1'b1;
         rx_wait--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      note_event e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_events.size() == 0) begin
            $error("unexpected note event");
            errors++;
         end else begin
            e = due_events.pop_front();
            if (rsp_wave_out !== e.wave) begin
               $error("wave_out exp %0d got %0d", e.wave, rsp_wave_out);
               errors++;
            end
            if (rsp_frequency_hz !== e.freq) begin
               $error("frequency_hz exp %0d got %0d", e.freq, rsp_frequency_hz);
               errors++;
            end
            if (rsp_duration_out_ms !== e.dur) begin
               $error("duration_out_ms exp %0d got %0d", e.dur, rsp_duration_out_ms);
               errors++;
            end
            if (rsp_gain !== e.gain) begin
               $error("gain exp %0d got %0d", e.gain, rsp_gain);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_last);
               errors++;
            end
         end
         rx_wait = idle_en ? $urandom_range(0, 4) : 0;
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic test_silence();
      send_tick(20'd1000000);
      send_play(SILENT_TRACK);
      send_slice(2'd3, 0, 5, 24'd0, 1'b0);   // slot out of range, ignored
      send_tick(20'd0);
   endtask

   task automatic test_fill_memory();
      seq_cmd c;
      for (int i = 0; i < LO_END; i++) begin
         c = rand_cmd(ACT_LOAD_NOTE);
         c.idx = 12'(i);
         c.t_ms = 24'(i);
         if (i == 0) begin
            c.pitch = 7'd0; c.vel = 7'd0; c.dur = 15'd0; c.wave = 2'd0;
         end else if (i == 1) begin
            c.pitch = 7'd127; c.vel = 7'd127; c.dur = 15'h7fff; c.wave = 2'd3;
         end
         send_item(c);
      end
      for (int i = HI_START; i < NOTE_DEPTH; i++) begin
         c = rand_cmd(ACT_LOAD_NOTE);
         c.idx = 12'(i);
         c.t_ms = (i == NOTE_DEPTH - 1) ? 24'hffffff : 24'($urandom_range(0, 3000));
         send_item(c);
      end
   endtask

   task automatic test_directed_play();
      send_slice(2'd0, 0, LO_END, 24'd1000, 1'b0);
      send_play(2'd0);
      send_tick(20'd250000);      // more due notes than one burst
      send_tick(20'd0);           // the rest fire now
      send_play(2'd0);            // same track, no effect
      send_slice(2'd1, HI_START, 4096, 24'd0, 1'b1);   // runs past memory end
      send_play(2'd1);
      send_tick(20'd250001);      // clamped and wraps
      send_tick(20'd0);
      send_slice(2'd2, 10, 0, 24'hffffff, 1'b0);
      send_play(2'd2);
      send_tick(20'd5000);        // empty slice
      send_play(2'd0);
      send_tick(20'd30000);
      send_slice(2'd0, 50, 30, 24'hffffff, 1'b0);   // cursor below new start
      send_tick(20'd100000);
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_slice(2'd0, 0, LO_END, 24'd2000, 1'b0);
      send_play(SILENT_TRACK);
      send_play(2'd0);
      rx_hold = 400;
      repeat (5) send_tick(20'd60000);
      wait_drained();
   endtask

   task automatic test_random(input int count);
      seq_cmd c;
      int r;
      int sel;
      bit hi;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            c = rand_cmd(ACT_LOAD_NOTE);
            c.idx = $urandom_range(0, 1) ? 12'($urandom_range(HI_START, NOTE_DEPTH - 1))
                                         : 12'($urandom_range(0, LO_END - 1));
            if ($urandom_range(0, 9) != 0) c.t_ms = 24'($urandom_range(0, 2000));
            send_item(c);
         end else if (r < 22) begin
            c.tid = 2'($urandom_range(0, 3));
            hi = (c.tid < TRACK_SLOTS && c.tid == playing) ? trk_hi[c.tid]
                                                           : 1'($urandom_range(0, 1));
            sel = $urandom_range(0, 3);
            c.len = (sel == 0) ? 24'd0 : (sel == 1) ? 24'd1 :
                    ($urandom_range(0, 7) == 0) ? 24'hffffff : 24'($urandom_range(1, 3000));
            if (hi) begin
               c.first = 12'($urandom_range(HI_START, NOTE_DEPTH - 1));
               c.count = ($urandom_range(0, 3) == 0) ? 13'd4096 : 13'($urandom_range(0, 100));
            end else begin
               c.first = 12'($urandom_range(0, LO_END - 1));
               c.count = 13'($urandom_range(0, LO_END - int'(c.first)));
            end
            send_slice(c.tid, int'(c.first), int'(c.count), c.len, hi);
         end else if (r < 30) begin
            send_play(2'($urandom_range(0, 3)));
         end else begin
            send_tick(($urandom_range(0, 7) == 0) ? 20'($urandom_range(250000, 1000000))
                                                  : 20'($urandom_range(0, 120000)));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_silence();
      test_fill_memory();
      test_directed_play();
      test_backpressure();
      test_random(120);
      idle_en = 1'b0;            // back-to-back stretch
      test_random(60);
      idle_en = 1'b1;
      wait_drained();
      test_random(80);
      wait_drained();
      repeat (50) @(negedge clock);
      if (due_events.size() != 0) begin
         $error("%0d note events never arrived", due_events.size());
         errors++;
      end
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/lnes_pkg.sv
sv/lnes_ram.sv
sv/lnes_rem.sv
sv/looping_note_event_sequencer.sv
sv/lnes_checker.sv
verif/looping_note_event_sequencer_test.sv
